FILE: src/p2rfp_pkg.sv
// Package with the shared types, codes and row geometry of the packed-to-RFP converter.
`timescale 1ns / 1ps

package p2rfp_pkg;

  localparam int MAX_ORDER = 256;
  localparam int ORDER_W = 9;
  localparam int ADDR_W = 17;
  localparam int COUNT_W = 16;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ORDER      = 2'd0,
    REG_LOWER      = 2'd1,
    REG_TRANSPOSED = 2'd2
  } cfg_reg_t;

  // Geometry of one loop nest: the rows it walks and how each row advances.
  typedef struct packed {
    logic [ORDER_W-1:0] cnt;
    logic [ADDR_W-1:0]  base0;
    logic [ADDR_W-1:0]  delta;
    logic [ADDR_W-1:0]  stride;
    logic [ORDER_W-1:0] len0;
    logic               len_up;
  } nest_t;

  typedef struct packed {
    logic [ORDER_W-1:0] n;
    logic [COUNT_W-1:0] total;
    nest_t [1:0]        nest;
  } geom_t;

  function automatic geom_t calc_geom(logic [ORDER_W-1:0] order, logic lower, logic tr);
    logic [ORDER_W-1:0] n;
    logic [ORDER_W-1:0] h;
    logic [ORDER_W-1:0] g;
    logic               odd;
    logic [ORDER_W-1:0] lda;
    logic [ADDR_W-1:0]  lda_w;
    logic [ADDR_W-1:0]  lda1;
    logic [ADDR_W-1:0]  prod;
    logic [ADDR_W-1:0]  tot;
    geom_t              r;
    n = (order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order;
    h = {1'b0, n[ORDER_W-1:1]};
    g = n - h;
    odd = n[0];
    if (odd) begin
      lda = tr ? g : n;
    end else begin
      lda = tr ? h : n + ORDER_W'(1);
    end
    lda_w = ADDR_W'(lda);
    lda1 = lda_w + ADDR_W'(1);
    prod = (ADDR_W'(h) + ADDR_W'(1)) * lda_w;
    tot = (ADDR_W'(n) * (ADDR_W'(n) + ADDR_W'(1))) >> 1;
    r.n = n;
    r.total = tot[COUNT_W-1:0];
    if (lower) begin
      r.nest[0].cnt = odd ? h + ORDER_W'(1) : h;
      r.nest[0].len0 = n;
      r.nest[0].len_up = 1'b0;
      r.nest[0].delta = lda1;
      r.nest[0].stride = tr ? lda_w : ADDR_W'(1);
      if (tr) begin
        r.nest[0].base0 = odd ? ADDR_W'(0) : lda_w;
      end else begin
        r.nest[0].base0 = odd ? ADDR_W'(0) : ADDR_W'(1);
      end
      r.nest[1].cnt = h;
      r.nest[1].len0 = h;
      r.nest[1].len_up = 1'b0;
      r.nest[1].delta = lda1;
      r.nest[1].stride = tr ? ADDR_W'(1) : lda_w;
      if (tr) begin
        r.nest[1].base0 = odd ? ADDR_W'(1) : ADDR_W'(0);
      end else begin
        r.nest[1].base0 = odd ? lda_w : ADDR_W'(0);
      end
    end else begin
      r.nest[0].cnt = h;
      r.nest[0].len0 = ORDER_W'(1);
      r.nest[0].len_up = 1'b1;
      r.nest[0].delta = tr ? lda_w : ADDR_W'(1);
      r.nest[0].stride = tr ? ADDR_W'(1) : lda_w;
      r.nest[0].base0 = tr ? prod : ADDR_W'(h) + ADDR_W'(1);
      r.nest[1].cnt = (odd && tr) ? h + ORDER_W'(1) : g;
      r.nest[1].len0 = h + ORDER_W'(1);
      r.nest[1].len_up = 1'b1;
      r.nest[1].delta = tr ? ADDR_W'(1) : lda_w;
      r.nest[1].stride = tr ? lda_w : ADDR_W'(1);
      r.nest[1].base0 = ADDR_W'(0);
    end
    return r;
  endfunction

endpackage

FILE: src/p2rfp_walk.sv
// Address walker that steps through the rows of the two loop nests, one element per item.
`timescale 1ns / 1ps

module p2rfp_walk (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         restart,
  input  logic                         step,
  input  p2rfp_pkg::geom_t             geom,
  output logic [p2rfp_pkg::COUNT_W-1:0] address,
  output logic                         last
);

  logic                              phase;
  logic [p2rfp_pkg::ORDER_W-1:0]     outer_count;
  logic [p2rfp_pkg::ADDR_W-1:0]      inner_address;
  logic [p2rfp_pkg::ADDR_W-1:0]      row_base;
  logic [p2rfp_pkg::COUNT_W-1:0]     element_count;
  logic [p2rfp_pkg::ORDER_W-1:0]     row_len;
  logic [p2rfp_pkg::ORDER_W-1:0]     col_left;

  logic                              phase_next;
  logic [p2rfp_pkg::ORDER_W-1:0]     outer_count_next;
  logic [p2rfp_pkg::ADDR_W-1:0]      inner_address_next;
  logic [p2rfp_pkg::ADDR_W-1:0]      row_base_next;
  logic [p2rfp_pkg::COUNT_W-1:0]     element_count_next;
  logic [p2rfp_pkg::ORDER_W-1:0]     row_len_next;
  logic [p2rfp_pkg::ORDER_W-1:0]     col_left_next;

  p2rfp_pkg::nest_t                  cur;
  p2rfp_pkg::nest_t                  first;
  logic                              start_phase;
  logic [p2rfp_pkg::COUNT_W:0]       count_inc;
  logic [p2rfp_pkg::ORDER_W:0]       outer_inc;
  logic                              at_end;
  logic                              row_end;
  logic                              nest_done;
  logic                              do_restart;
  logic [p2rfp_pkg::ADDR_W-1:0]      new_base;

  always_comb begin
    cur = geom.nest[phase];
    start_phase = (geom.nest[0].cnt == '0);
    first = geom.nest[start_phase];
    count_inc = {1'b0, element_count} + (p2rfp_pkg::COUNT_W+1)'(1);
    at_end = count_inc >= {1'b0, geom.total};
    row_end = (col_left == '0);
    outer_inc = {1'b0, outer_count} + (p2rfp_pkg::ORDER_W+1)'(1);
    nest_done = outer_inc >= {1'b0, cur.cnt};
    do_restart = restart || at_end ||
                 (row_end && nest_done && (phase || geom.nest[1].cnt == '0));
    new_base = row_base + cur.delta;

    phase_next = phase;
    outer_count_next = outer_count;
    inner_address_next = inner_address;
    row_base_next = row_base;
    element_count_next = count_inc[p2rfp_pkg::COUNT_W-1:0];
    row_len_next = row_len;
    col_left_next = col_left;

    priority if (do_restart) begin
      phase_next = start_phase;
      outer_count_next = '0;
      element_count_next = '0;
      row_base_next = first.base0;
      inner_address_next = first.base0;
      row_len_next = first.len0;
      col_left_next = first.len0 - p2rfp_pkg::ORDER_W'(1);
    end else if (row_end && nest_done) begin
      phase_next = 1'b1;
      outer_count_next = '0;
      row_base_next = geom.nest[1].base0;
      inner_address_next = geom.nest[1].base0;
      row_len_next = geom.nest[1].len0;
      col_left_next = geom.nest[1].len0 - p2rfp_pkg::ORDER_W'(1);
    end else if (row_end) begin
      outer_count_next = outer_inc[p2rfp_pkg::ORDER_W-1:0];
      row_base_next = new_base;
      inner_address_next = new_base;
      if (cur.len_up) begin
        row_len_next = row_len + p2rfp_pkg::ORDER_W'(1);
        col_left_next = row_len;
      end else begin
        row_len_next = row_len - p2rfp_pkg::ORDER_W'(1);
        col_left_next = row_len - p2rfp_pkg::ORDER_W'(2);
      end
    end else begin
      inner_address_next = inner_address + cur.stride;
      col_left_next = col_left - p2rfp_pkg::ORDER_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      outer_count <= '0;
      inner_address <= '0;
      row_base <= '0;
      element_count <= '0;
      row_len <= '0;
      col_left <= '0;
    end else if (restart || step) begin
      phase <= phase_next;
      outer_count <= outer_count_next;
      inner_address <= inner_address_next;
      row_base <= row_base_next;
      element_count <= element_count_next;
      row_len <= row_len_next;
      col_left <= col_left_next;
    end
  end

  assign address = inner_address[p2rfp_pkg::COUNT_W-1:0];
  assign last = at_end;

endmodule

FILE: src/packed_to_rfp_layout_converter.sv
// Top level of the packed-to-RFP converter: configuration registers, geometry and result register.
`timescale 1ns / 1ps

// The block accepts one packed matrix element per clock cycle while the input is not stalled
// and returns it in the following cycle in the result register, together with its zero-based
// address in rectangular full packed storage and a last flag on the final element of the
// matrix. The address comes from running row counters that advance by one stride per item,
// so the rate is one item per cycle unless the input is stalled. After reset and after each
// write to a known configuration register the input is stalled while the row geometry is
// recomputed, with its two small multiplications, and then while the walk restarts at the
// first element. With an order of zero each item comes back with address zero and last set.
module packed_to_rfp_layout_converter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [63:0]                      element,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [63:0]                      element_out,
  output logic [15:0]                      rfp_address,
  output logic                             last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [p2rfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [p2rfp_pkg::ORDER_W-1:0]    cfg_data
);

  logic [p2rfp_pkg::ORDER_W-1:0]  order;
  logic                           lower_triangle;
  logic                           transposed_layout;
  logic                           pend_geom;
  logic                           pend_restart;
  p2rfp_pkg::geom_t               geom;

  logic                           cfg_fire;
  logic                           cfg_hit;
  logic                           fire;
  logic [p2rfp_pkg::COUNT_W-1:0]  walk_address;
  logic                           walk_last;
  logic                           order_zero;

  assign cfg_ready = 1'b1;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign in_stall = rst || pend_geom || pend_restart || (out_valid && out_stall);
  assign fire = in_valid && !in_stall;
  assign order_zero = (geom.n == '0);

  always_comb begin
    unique case (cfg_index)
      p2rfp_pkg::REG_ORDER,
      p2rfp_pkg::REG_LOWER,
      p2rfp_pkg::REG_TRANSPOSED: cfg_hit = cfg_fire;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= '0;
      lower_triangle <= 1'b1;
      transposed_layout <= 1'b0;
      pend_geom <= 1'b1;
      pend_restart <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          p2rfp_pkg::REG_ORDER: order <= cfg_data;
          p2rfp_pkg::REG_LOWER: lower_triangle <= cfg_data[0];
          p2rfp_pkg::REG_TRANSPOSED: transposed_layout <= cfg_data[0];
          default: ;
        endcase
      end
      pend_geom <= cfg_hit;
      pend_restart <= pend_geom && !cfg_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_geom) begin
      geom <= p2rfp_pkg::calc_geom(order, lower_triangle, transposed_layout);
    end
  end

  p2rfp_walk u_walk (
    .clk     (clk),
    .rst     (rst),
    .restart (pend_restart),
    .step    (fire && !order_zero),
    .geom    (geom),
    .address (walk_address),
    .last    (walk_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      element_out <= element;
      rfp_address <= order_zero ? '0 : walk_address;
      last <= order_zero || walk_last;
    end
  end

endmodule
